@@ rtl/jpae_pkg.sv @@
package jpae_pkg;

    // Node numbers, depths and step counts share one width
    localparam int NODE_W     = 10;
    localparam int NODE_COUNT = 1024;

    // Climb count holds up to twice the deepest depth
    localparam int CNT_W = NODE_W + 1;
    // Signed path length: depth sums minus twice a depth
    localparam int DST_W = NODE_W + 2;
    // LCA round counter reaches NODE_COUNT itself
    localparam int ROUND_W = $clog2(NODE_COUNT) + 1;
    localparam logic [ROUND_W-1:0] ROUND_LIMIT = ROUND_W'(NODE_COUNT);

    typedef logic [NODE_W-1:0] node_t;

    // Command codes
    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_ANCESTOR = 2'd1;
    localparam logic [1:0] CMD_LCA      = 2'd2;
    localparam logic [1:0] CMD_PATH     = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        node_t       node_a;
        node_t       node_b;
        logic [9:0]  count_k;
        logic        is_root;
    } req_t;

    typedef struct packed {
        node_t       result_node;
        logic        status;
    } rsp_t;

    // One table row: parent, depth and jump pointer of a node
    typedef struct packed {
        node_t       parent;
        node_t       depth;
        node_t       jump;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage

@@ rtl/jpae_ram.sv @@
module jpae_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/jump_pointer_ancestor_engine_unit.sv @@
// Insert: a child reads its parent, jump and jump's-jump rows, then writes its row.
// Queries: a climb jumps in S_CLIMB_J or steps to a parent via S_CLIMB_P; an LCA
// round: S_LCA_LOOP, S_LCA_RX, S_LCA_RY; unconnected nodes add up to 1024 rounds.
// One request at a time, paced by the single table read port; busy drops with done.
// Reset clears the sequencer only; table contents are undefined until written.
// The receiver cannot stall: done is high for exactly one cycle per result.
module jump_pointer_ancestor_engine_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  jpae_pkg::req_t request,
    output logic           done,
    output jpae_pkg::rsp_t result
);

    import jpae_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_INS_P,
        S_INS_J,
        S_INS_JJ,
        S_CLIMB_RD,
        S_CLIMB_INIT,
        S_CLIMB_J,
        S_CLIMB_P,
        S_CLIMB_END,
        S_LCA_A,
        S_LCA_B,
        S_LCA_LOOP,
        S_LCA_RX,
        S_LCA_RY,
        S_LCA_RES,
        S_PATH
    } state_t;

    // Where a finished climb hands control back to
    typedef enum logic {
        RET_FINAL,
        RET_LCA
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;
    rsp_t   rsp_reg, rsp_next;
    logic   done_reg, done_next;

    req_t              req_reg, req_next;
    node_t             x_reg, x_next;
    rec_t              x_rec_reg, x_rec_next;
    node_t             v_reg, v_next;
    rec_t              v_rec_reg, v_rec_next;
    logic [CNT_W-1:0]  ck_reg, ck_next;
    logic              bad_reg, bad_next;
    node_t             dep_a_reg, dep_a_next;
    node_t             dep_b_reg, dep_b_next;
    node_t             lc_reg, lc_next;
    logic [ROUND_W-1:0] rounds_reg, rounds_next;
    node_t             dp_reg, dp_next;
    node_t             djp_reg, djp_next;
    node_t             jjp_reg, jjp_next;

    // Node table port
    logic              wr_en;
    node_t             wr_addr;
    rec_t              wr_rec;
    node_t             rd_addr;
    logic [REC_W-1:0]  ram_rdata;
    rec_t              rd_rec;

    // Shared datapath terms
    logic [CNT_W-1:0]  rise;
    logic              taken;
    logic [CNT_W-1:0]  ck_step;
    logic [CNT_W-1:0]  ins_sum;
    logic [CNT_W-1:0]  ins_dbl;
    logic              ins_eq;
    logic              loop_go;
    logic              jump_eq;
    node_t             nx;
    node_t             ny;
    logic [DST_W-1:0]  path_dst;
    logic [DST_W-1:0]  path_d1;
    logic [DST_W-1:0]  path_rem;
    logic [DST_W-1:0]  k_ext;
    logic              path_bad;
    logic              k_le_d1;

    jpae_ram #(
        .WIDTH (REC_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_rec),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign rd_rec = rec_t'(ram_rdata);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    // Climb step: take the jump when it rises 1..k levels, else one parent step
    always_comb
    begin
        rise    = {1'b0, v_rec_reg.depth} - {1'b0, rd_rec.depth};
        taken   = !rise[CNT_W-1] && (rise != '0) && (rise <= ck_reg);
        ck_step = taken ? (ck_reg - rise) : (ck_reg - CNT_W'(1));
    end

    // Insert: skew-binary test dep(p) + dep(jj) == 2 * dep(j)
    always_comb
    begin
        ins_sum = {1'b0, dp_reg} + {1'b0, rd_rec.depth};
        ins_dbl = {djp_reg, 1'b0};
        ins_eq  = (ins_sum == ins_dbl);
    end

    // LCA round: move both nodes by jump, or by parent when jumps meet
    always_comb
    begin
        loop_go = (x_rec_reg.parent != v_rec_reg.parent) && (rounds_reg < ROUND_LIMIT);
        jump_eq = (x_rec_reg.jump == v_rec_reg.jump);
        nx      = jump_eq ? x_rec_reg.parent : x_rec_reg.jump;
        ny      = jump_eq ? v_rec_reg.parent : v_rec_reg.jump;
    end

    // Path query: length, side of the LCA and climb count
    always_comb
    begin
        k_ext    = {2'b00, req_reg.count_k};
        path_dst = {2'b00, dep_a_reg} + {2'b00, dep_b_reg} - {1'b0, rd_rec.depth, 1'b0};
        path_d1  = {2'b00, dep_a_reg} - {2'b00, rd_rec.depth};
        path_rem = path_dst - k_ext;
        path_bad = path_dst[DST_W-1] || (k_ext > path_dst);
        k_le_d1  = !path_d1[DST_W-1] && (k_ext <= path_d1);
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        req_next    = req_reg;
        x_next      = x_reg;
        x_rec_next  = x_rec_reg;
        v_next      = v_reg;
        v_rec_next  = v_rec_reg;
        ck_next     = ck_reg;
        bad_next    = bad_reg;
        dep_a_next  = dep_a_reg;
        dep_b_next  = dep_b_reg;
        lc_next     = lc_reg;
        rounds_next = rounds_reg;
        dp_next     = dp_reg;
        djp_next    = djp_reg;
        jjp_next    = jjp_reg;
        rd_addr     = v_reg;
        wr_en       = 1'b0;
        wr_addr     = req_reg.node_a;
        wr_rec      = '{parent: req_reg.node_b,
                        depth:  dp_reg + NODE_W'(1),
                        jump:   ins_eq ? jjp_reg : req_reg.node_b};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                case (req_reg.command)
                    CMD_INSERT:
                    begin
                        rd_addr = req_reg.node_b;
                        if (req_reg.is_root)
                        begin
                            wr_en      = 1'b1;
                            wr_rec     = '{parent: req_reg.node_a, depth: '0,
                                           jump: req_reg.node_a};
                            rsp_next   = '{result_node: req_reg.node_a, status: 1'b0};
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_INS_P;
                        end
                    end
                    CMD_ANCESTOR:
                    begin
                        v_next     = req_reg.node_a;
                        ck_next    = {1'b0, req_reg.count_k};
                        ret_next   = RET_FINAL;
                        state_next = S_CLIMB_RD;
                    end
                    default:
                    begin
                        rd_addr    = req_reg.node_a;
                        state_next = S_LCA_A;
                    end
                endcase
            end

            // Insert of a child: parent row, its jump row, then the jump's jump
            S_INS_P:
            begin
                dp_next    = rd_rec.depth;
                rd_addr    = rd_rec.jump;
                state_next = S_INS_J;
            end

            S_INS_J:
            begin
                djp_next   = rd_rec.depth;
                jjp_next   = rd_rec.jump;
                rd_addr    = rd_rec.jump;
                state_next = S_INS_JJ;
            end

            S_INS_JJ:
            begin
                wr_en      = 1'b1;
                rsp_next   = '{result_node: req_reg.node_a, status: 1'b0};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // Climb from v by ck levels
            S_CLIMB_RD:
            begin
                rd_addr    = v_reg;
                bad_next   = 1'b0;
                state_next = S_CLIMB_INIT;
            end

            S_CLIMB_INIT:
            begin
                v_rec_next = rd_rec;
                rd_addr    = rd_rec.jump;
                if (ck_reg > {1'b0, rd_rec.depth})
                begin
                    bad_next   = 1'b1;
                    state_next = S_CLIMB_END;
                end
                else if (ck_reg == '0)
                begin
                    state_next = S_CLIMB_END;
                end
                else
                begin
                    state_next = S_CLIMB_J;
                end
            end

            S_CLIMB_J:
            begin
                ck_next = ck_step;
                if (taken)
                begin
                    v_next     = v_rec_reg.jump;
                    v_rec_next = rd_rec;
                    rd_addr    = rd_rec.jump;
                    if (ck_step == '0)
                    begin
                        state_next = S_CLIMB_END;
                    end
                end
                else
                begin
                    v_next     = v_rec_reg.parent;
                    rd_addr    = v_rec_reg.parent;
                    state_next = S_CLIMB_P;
                end
            end

            S_CLIMB_P:
            begin
                v_rec_next = rd_rec;
                rd_addr    = rd_rec.jump;
                if (ck_reg == '0)
                begin
                    state_next = S_CLIMB_END;
                end
                else
                begin
                    state_next = S_CLIMB_J;
                end
            end

            S_CLIMB_END:
            begin
                if (ret_reg == RET_FINAL)
                begin
                    rsp_next   = '{result_node: bad_reg ? '0 : v_reg, status: bad_reg};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (x_reg == v_reg)
                begin
                    lc_next    = x_reg;
                    state_next = S_LCA_RES;
                end
                else
                begin
                    rounds_next = '0;
                    state_next  = S_LCA_LOOP;
                end
            end

            // LCA: fetch both rows, lift the deeper node to the other's depth
            S_LCA_A:
            begin
                x_next     = req_reg.node_a;
                x_rec_next = rd_rec;
                dep_a_next = rd_rec.depth;
                rd_addr    = req_reg.node_b;
                state_next = S_LCA_B;
            end

            S_LCA_B:
            begin
                dep_b_next = rd_rec.depth;
                ret_next   = RET_LCA;
                state_next = S_CLIMB_RD;
                if (dep_a_reg > rd_rec.depth)
                begin
                    x_next     = req_reg.node_b;
                    x_rec_next = rd_rec;
                    v_next     = req_reg.node_a;
                    ck_next    = {1'b0, dep_a_reg - rd_rec.depth};
                end
                else
                begin
                    v_next  = req_reg.node_b;
                    ck_next = {1'b0, rd_rec.depth - dep_a_reg};
                end
            end

            S_LCA_LOOP:
            begin
                rd_addr = nx;
                if (loop_go)
                begin
                    x_next      = nx;
                    v_next      = ny;
                    rounds_next = rounds_reg + ROUND_W'(1);
                    state_next  = S_LCA_RX;
                end
                else
                begin
                    lc_next    = x_rec_reg.parent;
                    state_next = S_LCA_RES;
                end
            end

            S_LCA_RX:
            begin
                x_rec_next = rd_rec;
                rd_addr    = v_reg;
                state_next = S_LCA_RY;
            end

            S_LCA_RY:
            begin
                v_rec_next = rd_rec;
                state_next = S_LCA_LOOP;
            end

            S_LCA_RES:
            begin
                rd_addr = lc_reg;
                if (req_reg.command == CMD_LCA)
                begin
                    rsp_next   = '{result_node: lc_reg, status: 1'b0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_PATH;
                end
            end

            // Path: pick the side of the LCA that holds the k-th vertex
            S_PATH:
            begin
                if (path_bad)
                begin
                    rsp_next   = '{result_node: '0, status: 1'b1};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ret_next   = RET_FINAL;
                    state_next = S_CLIMB_RD;
                    if (k_le_d1)
                    begin
                        v_next  = req_reg.node_a;
                        ck_next = {1'b0, req_reg.count_k};
                    end
                    else
                    begin
                        v_next  = req_reg.node_b;
                        ck_next = path_rem[CNT_W-1:0];
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_FINAL;
            rsp_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            rsp_reg   <= rsp_next;
            done_reg  <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        x_reg      <= x_next;
        x_rec_reg  <= x_rec_next;
        v_reg      <= v_next;
        v_rec_reg  <= v_rec_next;
        ck_reg     <= ck_next;
        bad_reg    <= bad_next;
        dep_a_reg  <= dep_a_next;
        dep_b_reg  <= dep_b_next;
        lc_reg     <= lc_next;
        rounds_reg <= rounds_next;
        dp_reg     <= dp_next;
        djp_reg    <= djp_next;
        jjp_reg    <= jjp_next;
    end

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) && !busy)
        else $error("done without a request in flight");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status |-> result.result_node == '0)
        else $error("out-of-range result carries a node");

    a_bad_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status |->
            req_reg.command == CMD_ANCESTOR || req_reg.command == CMD_PATH)
        else $error("out-of-range status on a command without k");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> busy && req_reg.command == CMD_INSERT)
        else $error("table write outside an insert");

endmodule

@@ tb/jpae_answer_checker.sv @@
`timescale 1ns / 1ps

module jpae_answer_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  jpae_pkg::req_t   request,
    input  logic             done,
    input  jpae_pkg::rsp_t   result,
    output int unsigned      fail_count,
    output int unsigned      pending,
    output int unsigned      checked
);
    import jpae_pkg::*;

    // Shadow tree tables: parent, depth and skew-binary jump per node
    bit [NODE_W-1:0] up_tab  [NODE_COUNT];
    bit [NODE_W-1:0] lvl_tab [NODE_COUNT];
    bit [NODE_W-1:0] hop_tab [NODE_COUNT];

    // Answers owed by the engine, oldest first, with the request that caused each
    rsp_t answer_q [$];
    req_t asked_q  [$];

    int unsigned fails = 0;
    int unsigned seen  = 0;

    function automatic int lvl(input node_t v);
        return int'(lvl_tab[v]);
    endfunction

    // Walk steps levels up; jump when the jump lands inside the remaining count
    function automatic node_t climb_by(input node_t from, input int steps, output bit oor);
        node_t v;
        node_t u;
        int    k;
        int    rise;
        v   = from;
        k   = steps;
        oor = 1'b0;
        if (k < 0 || k > lvl(v))
        begin
            oor = 1'b1;
            return '0;
        end
        while (k > 0)
        begin
            u    = hop_tab[v];
            rise = lvl(v) - lvl(u);
            if (rise >= 1 && rise <= k)
            begin
                v = u;
                k -= rise;
            end
            else
            begin
                v = up_tab[v];
                k--;
            end
        end
        return v;
    endfunction

    // Lowest common ancestor; nodes in different trees stop after NODE_COUNT rounds
    function automatic node_t meet_of(input node_t p, input node_t q);
        node_t x;
        node_t y;
        node_t t;
        int    rounds;
        bit    unused_oor;
        x = p;
        y = q;
        if (lvl(x) > lvl(y))
        begin
            t = x;
            x = y;
            y = t;
        end
        y = climb_by(y, lvl(y) - lvl(x), unused_oor);
        if (x == y)
            return x;
        rounds = 0;
        while (up_tab[x] != up_tab[y] && rounds < NODE_COUNT)
        begin
            if (hop_tab[x] == hop_tab[y])
            begin
                x = up_tab[x];
                y = up_tab[y];
            end
            else
            begin
                x = hop_tab[x];
                y = hop_tab[y];
            end
            rounds++;
        end
        return up_tab[x];
    endfunction

    // Expected answer for one request; an insert also updates the shadow tables
    function automatic rsp_t answer_of(input req_t r);
        rsp_t  o;
        node_t a;
        node_t b;
        node_t jp;
        node_t jjp;
        node_t lc;
        int    k;
        int    dp;
        int    dst;
        bit    oor;
        a   = r.node_a;
        b   = r.node_b;
        k   = int'(r.count_k);
        oor = 1'b0;
        o   = '0;
        case (r.command)
            CMD_INSERT:
            begin
                if (r.is_root)
                begin
                    up_tab[a]  = a;
                    lvl_tab[a] = '0;
                    hop_tab[a] = a;
                end
                else
                begin
                    // read everything from the parent before the new row lands
                    jp  = hop_tab[b];
                    jjp = hop_tab[jp];
                    dp  = lvl(b);
                    hop_tab[a] = (dp + lvl(jjp) == 2 * lvl(jp)) ? jjp : b;
                    up_tab[a]  = b;
                    lvl_tab[a] = node_t'(dp + 1);
                end
                o.result_node = a;
            end
            CMD_ANCESTOR:
                o.result_node = climb_by(a, k, oor);
            CMD_LCA:
                o.result_node = meet_of(a, b);
            default:
            begin
                // k-th vertex on the path
                lc  = meet_of(a, b);
                dst = lvl(a) + lvl(b) - 2 * lvl(lc);
                if (dst < 0 || k > dst)
                    oor = 1'b1;
                else if (k <= lvl(a) - lvl(lc))
                    o.result_node = climb_by(a, k, oor);
                else
                    o.result_node = climb_by(b, dst - k, oor);
            end
        endcase
        if (oor)
            o.result_node = '0;
        o.status = oor;
        return o;
    endfunction

    // Check each done strobe against the oldest answer, then log a new request
    always @(posedge clk)
    begin
        rsp_t want;
        req_t asked;
        if (rst_n)
        begin
            if (done)
            begin
                if (answer_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: result with no request pending: expected none, got %0d/%0d",
                             $time, result.result_node, result.status);
                end
                else
                begin
                    want  = answer_q.pop_front();
                    asked = asked_q.pop_front();
                    seen++;
                    if (result.result_node !== want.result_node)
                    begin
                        fails++;
                        $display("%0t: cmd %0d a=%0d b=%0d k=%0d: result_node expected %0d, got %0d",
                                 $time, asked.command, asked.node_a, asked.node_b,
                                 asked.count_k, want.result_node, result.result_node);
                    end
                    if (result.status !== want.status)
                    begin
                        fails++;
                        $display("%0t: cmd %0d a=%0d b=%0d k=%0d: status expected %0d, got %0d",
                                 $time, asked.command, asked.node_a, asked.node_b,
                                 asked.count_k, want.status, result.status);
                    end
                end
            end
            if (start && !busy)
            begin
                answer_q.push_back(answer_of(request));
                asked_q.push_back(request);
            end
            fail_count <= fails;
            pending    <= answer_q.size();
            checked    <= seen;
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import jpae_pkg::*;

    localparam int CLOCK_LIMIT   = 20_000_000;
    localparam int RANDOM_ITEMS  = 600;
    localparam int CHAIN_NODES   = 128;
    localparam int SETTLE_CYCLES = 40;

    logic clk;
    logic rst_n   = 1'b0;
    logic start   = 1'b0;
    logic busy;
    req_t request = '0;
    logic done;
    rsp_t result;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned idle_pct = 0;
    int unsigned cycles   = 0;

    // Stimulus-side view of the forest, only to aim requests at stored nodes
    bit          present [NODE_COUNT];
    int          level   [NODE_COUNT];
    int          grove   [NODE_COUNT];
    int          placed  [$];
    int          last_node = 0;
    int unsigned sent    [4];
    int unsigned roots = 0;

    jump_pointer_ancestor_engine_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    jpae_answer_checker answers (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CLOCK_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles, %0d answers still owed",
                     $time, CLOCK_LIMIT, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int noise();
        return $urandom_range(0, NODE_COUNT - 1);
    endfunction

    function automatic int pick_node();
        return placed[$urandom_range(0, placed.size() - 1)];
    endfunction

    // Mostly a node that was never stored
    function automatic int pick_fresh();
        int n;
        int tries;
        n     = noise();
        tries = 0;
        while (present[n] && tries < 32)
        begin
            n = noise();
            tries++;
        end
        return n;
    endfunction

    // Second node, usually in the same tree so the chase stays short
    function automatic int pick_partner(input int a);
        int b;
        int tries;
        b = pick_node();
        if ($urandom_range(0, 99) < 4)
            return b;
        tries = 0;
        while (grove[b] != grove[a] && tries < 8)
        begin
            b = pick_node();
            tries++;
        end
        return b;
    endfunction

    // Step count aimed around the reachable span, with edges and wild values
    function automatic int pick_steps(input int span);
        int s;
        s = (span > NODE_COUNT - 1) ? NODE_COUNT - 1 : span;
        case ($urandom_range(0, 9))
            0:       return noise();
            1:       return (s < NODE_COUNT - 1) ? s + 1 : s;
            2:       return s;
            default: return $urandom_range(0, s);
        endcase
    endfunction

    // Drive one request, idling at random, and hold it until accepted
    task automatic issue(input logic [1:0] cmd, input int a, input int b, input int k,
                         input bit root);
        req_t r;
        bit   taken;
        r.command = cmd;
        r.node_a  = node_t'(a);
        r.node_b  = node_t'(b);
        r.count_k = 10'(k);
        r.is_root = root;
        taken     = 1'b0;
        request  <= r;
        while (!taken)
        begin
            if ($urandom_range(0, 99) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                start <= 1'b1;
                @(posedge clk);
                taken = !busy;
            end
        end
        // bookkeeping for later picks
        sent[cmd]++;
        if (cmd == CMD_INSERT)
        begin
            if (!present[a])
            begin
                present[a] = 1'b1;
                placed.push_back(a);
            end
            if (root)
            begin
                level[a] = 0;
                grove[a] = a;
                roots++;
            end
            else
            begin
                level[a] = (level[b] + 1) % NODE_COUNT;
                grove[a] = grove[b];
            end
            last_node = a;
        end
    endtask

    task automatic query(input logic [1:0] cmd, input int a, input int b);
        issue(cmd, a, b,
              (cmd == CMD_PATH) ? pick_steps(level[a] + level[b]) : pick_steps(level[a]),
              1'($urandom_range(0, 1)));
    endtask

    // One random request: growth of the forest or a query on stored nodes
    task automatic random_item();
        int a;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            a = ($urandom_range(0, 99) < 3) ? pick_node() : pick_fresh();
            if ($urandom_range(0, 99) < 4)
                issue(CMD_INSERT, a, noise(), noise(), 1'b1);
            else
                issue(CMD_INSERT, a, ($urandom_range(0, 1) != 0) ? last_node : pick_node(),
                      noise(), 1'b0);
        end
        else
        begin
            a = pick_node();
            if (pick < 55)
                query(CMD_ANCESTOR, a, noise());
            else if (pick < 75)
                query(CMD_LCA, a, pick_partner(a));
            else
                query(CMD_PATH, a, pick_partner(a));
        end
    endtask

    task automatic chain_query(input int top);
        query(2'($urandom_range(CMD_ANCESTOR, CMD_PATH)), $urandom_range(0, top),
              $urandom_range(0, top));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: two trees, field extremes, every command and its edge cases
        issue(CMD_INSERT, 0, NODE_COUNT - 1, NODE_COUNT - 1, 1'b1);
        issue(CMD_INSERT, NODE_COUNT - 1, 0, 0, 1'b0);
        issue(CMD_INSERT, 1, NODE_COUNT - 1, noise(), 1'b0);
        issue(CMD_INSERT, 2, 1, noise(), 1'b0);
        issue(CMD_INSERT, 3, 2, noise(), 1'b0);
        issue(CMD_INSERT, 4, 3, noise(), 1'b0);
        issue(CMD_INSERT, 6, 0, noise(), 1'b0);
        issue(CMD_INSERT, 7, 6, noise(), 1'b0);
        issue(CMD_INSERT, 1000, noise(), noise(), 1'b1);
        issue(CMD_INSERT, 1001, 1000, noise(), 1'b0);
        issue(CMD_ANCESTOR, 4, noise(), 0, 1'b0);
        issue(CMD_ANCESTOR, 4, noise(), 5, 1'b1);
        issue(CMD_ANCESTOR, 4, noise(), 6, 1'b0);
        issue(CMD_ANCESTOR, 4, noise(), NODE_COUNT - 1, 1'b1);
        issue(CMD_ANCESTOR, 0, noise(), 0, 1'b0);
        issue(CMD_LCA, 4, 7, noise(), 1'b0);
        issue(CMD_LCA, 3, 3, noise(), 1'b1);
        issue(CMD_LCA, 4, 2, noise(), 1'b0);
        issue(CMD_LCA, 1001, 4, noise(), 1'b0);
        issue(CMD_PATH, 4, 7, 0, 1'b0);
        issue(CMD_PATH, 4, 7, 7, 1'b1);
        issue(CMD_PATH, 4, 7, 6, 1'b0);
        issue(CMD_PATH, 4, 7, 8, 1'b0);
        issue(CMD_PATH, 4, 7, NODE_COUNT - 1, 1'b1);
        issue(CMD_PATH, 1001, 4, 1, 1'b0);

        // Random forest growth and queries under three idle patterns
        idle_pct = 30;
        repeat (RANDOM_ITEMS / 3) random_item();
        idle_pct = 47;
        repeat (RANDOM_ITEMS / 3) random_item();
        idle_pct = 0;
        repeat (RANDOM_ITEMS / 3) random_item();

        // One chain over the low node numbers, probed as it grows
        issue(CMD_INSERT, 0, noise(), noise(), 1'b1);
        for (int i = 1; i < CHAIN_NODES; i++)
        begin
            issue(CMD_INSERT, i, i - 1, noise(), 1'b0);
            if (i % 64 == 63)
                repeat (6) chain_query(i);
        end
        issue(CMD_ANCESTOR, CHAIN_NODES - 1, noise(), CHAIN_NODES - 1, 1'b0);
        issue(CMD_ANCESTOR, CHAIN_NODES - 1, noise(), CHAIN_NODES - 2, 1'b1);
        issue(CMD_ANCESTOR, CHAIN_NODES - 1, noise(), CHAIN_NODES, 1'b0);
        issue(CMD_ANCESTOR, CHAIN_NODES - 1, noise(), 0, 1'b0);
        issue(CMD_LCA, CHAIN_NODES - 1, CHAIN_NODES / 2 - 1, noise(), 1'b0);
        issue(CMD_PATH, CHAIN_NODES - 1, 0, CHAIN_NODES - 1, 1'b0);
        issue(CMD_PATH, 90, 30, 60, 1'b1);
        repeat (16) chain_query(CHAIN_NODES - 1);
        start <= 1'b0;

        // Drain, then let the engine settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d inserts (%0d as root), %0d ancestor, %0d LCA and %0d path requests;",
                 sent[CMD_INSERT], roots, sent[CMD_ANCESTOR], sent[CMD_LCA], sent[CMD_PATH]);
        $display("checked %0d results over random forests and a %0d-node chain.",
                 checked, CHAIN_NODES);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/jpae_pkg.sv
rtl/jpae_ram.sv
rtl/jump_pointer_ancestor_engine_unit.sv
tb/jpae_answer_checker.sv
tb/tb_top.sv
